// File: src/glyph_outline_classifier_core_macros.svh
// Assertion macros used by the checker file of the outline classifier.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GLYPH_OUTLINE_CLASSIFIER_CORE_MACROS_SVH
`define GLYPH_OUTLINE_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define GOC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/goc_pkg.sv
`timescale 1ns / 1ps

package goc_pkg;

    localparam int LINE_WIDTH  = 128;
    localparam int MAX_ROWS    = 128;
    localparam int MIN_WIDTH   = 2;

    localparam int COL_W       = $clog2(LINE_WIDTH);
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int WIDTH_W     = 8;
    localparam int CODE_W      = 8;
    localparam int OUT_ROW_W   = 7;
    localparam int OUT_COL_W   = 7;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 16;

    // One bit per bank: a line store word holds both banks of one column.
    localparam int STORE_W     = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0]  SPACE_CODE    = 8'd32;
    localparam logic [WIDTH_W-1:0] WIDTH_DEFAULT = 8'd128;

    typedef enum logic [1:0] {
        CLASS_BACKGROUND = 2'd0,
        CLASS_GLYPH      = 2'd1,
        CLASS_OUTLINE    = 2'd2
    } pixel_class_t;

    typedef struct packed {
        logic                 last_of_frame;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] column;
        pixel_class_t         pixel_class;
    } result_t;

endpackage

// File: src/goc_ram.sv
`timescale 1ns / 1ps

// Generic RAM: one write port, two read ports, registered read data.
module goc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

// File: src/goc_front.sv
`timescale 1ns / 1ps

// Front end: width register, row and column counters, line store lookup and
// pixel classification. One request per cycle while the queue has space.
module goc_front import goc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WIDTH_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CODE_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic [QCNT_W-1:0]  q_count,
    output logic               push,
    output result_t            push_item
);

    logic [WIDTH_W-1:0] width_reg;
    logic [WIDTH_W-1:0] w_use;

    logic [COL_W-1:0]   col_reg, col_next, col_base, cur_col;
    logic [ROW_W-1:0]   row_reg, row_next, row_base, cur_row;
    logic [WIDTH_W-1:0] col_inc;
    logic               wrap, end_row, accept, in_first, in_flush, in_bit;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_bit_reg, s1_right_ok_reg, s1_last_reg;
    logic               s1_fwd_a_reg, s1_fwd_b_reg, s1_vld_a_reg, s1_vld_b_reg;
    logic [STORE_W-1:0] fwd_word_reg;
    logic               left_reg;
    logic [LINE_WIDTH-1:0] store_valid_reg;

    logic [STORE_W-1:0] rd_data_a, rd_data_b, word_a, word_b, wr_word;
    logic               par, self_bit, left_bit, right_bit, above_bit;
    logic [ROW_W-1:0]   row_minus;
    pixel_class_t       cls;

    function automatic logic [ROW_W-1:0] advance_row(input logic [ROW_W-1:0] r);
        advance_row = (r >= ROW_W'(MAX_ROWS)) ? '0 : r + ROW_W'(1);
    endfunction

    // Width clamped into the legal range.
    always_comb
    begin
        if (width_reg < WIDTH_W'(MIN_WIDTH))
        begin
            w_use = WIDTH_W'(MIN_WIDTH);
        end
        else if (width_reg > WIDTH_W'(LINE_WIDTH))
        begin
            w_use = WIDTH_W'(LINE_WIDTH);
        end
        else
        begin
            w_use = width_reg;
        end
    end

    assign s_tready = (q_count + QCNT_W'(s1_valid_reg)) < QCNT_W'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign in_first = s_tuser[0];
    assign in_flush = s_tuser[1];
    assign in_bit   = !in_flush && (s_tdata != SPACE_CODE);

    // Position of the incoming pixel, and the counters after it.
    always_comb
    begin
        col_base = in_first ? '0 : col_reg;
        row_base = in_first ? '0 : row_reg;
        wrap     = WIDTH_W'(col_base) >= w_use;
        cur_col  = wrap ? '0 : col_base;
        cur_row  = wrap ? advance_row(row_base) : row_base;
        col_inc  = WIDTH_W'(cur_col) + WIDTH_W'(1);
        end_row  = col_inc >= w_use;
        col_next = end_row ? '0 : col_inc[COL_W-1:0];
        row_next = end_row ? advance_row(cur_row) : cur_row;
    end

    goc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (LINE_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .we        (s1_valid_reg),
        .wr_addr   (s1_col_reg),
        .wr_data   (wr_word),
        .rd_addr_a (cur_col),
        .rd_addr_b (col_inc[COL_W-1:0]),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Classification of the pixel above the incoming one.
    always_comb
    begin
        par       = s1_row_reg[0];
        word_a    = s1_fwd_a_reg ? fwd_word_reg : (s1_vld_a_reg ? rd_data_a : '0);
        word_b    = s1_fwd_b_reg ? fwd_word_reg : (s1_vld_b_reg ? rd_data_b : '0);
        self_bit  = word_a[~par];
        left_bit  = (s1_col_reg != '0) && left_reg;
        right_bit = s1_right_ok_reg && word_b[~par];
        above_bit = (s1_row_reg >= ROW_W'(2)) && word_a[par];
        if (self_bit)
        begin
            cls = CLASS_GLYPH;
        end
        else if (left_bit || right_bit || above_bit || s1_bit_reg)
        begin
            cls = CLASS_OUTLINE;
        end
        else
        begin
            cls = CLASS_BACKGROUND;
        end
        wr_word       = '0;
        wr_word[par]  = s1_bit_reg;
        wr_word[~par] = self_bit;
        row_minus     = s1_row_reg - ROW_W'(1);
    end

    assign push                    = s1_valid_reg && (s1_row_reg != '0);
    assign push_item.pixel_class   = cls;
    assign push_item.column        = s1_col_reg;
    assign push_item.row           = row_minus[OUT_ROW_W-1:0];
    assign push_item.last_of_frame = s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= WIDTH_DEFAULT;
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            store_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_wdata;
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                store_valid_reg[s1_col_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= cur_col;
            s1_row_reg      <= cur_row;
            s1_bit_reg      <= in_bit;
            s1_right_ok_reg <= col_inc < w_use;
            s1_last_reg     <= in_flush && (col_inc == w_use);
            // The word written at this same edge is passed straight across.
            s1_fwd_a_reg    <= s1_valid_reg && (s1_col_reg == cur_col);
            s1_fwd_b_reg    <= s1_valid_reg && (s1_col_reg == col_inc[COL_W-1:0]);
            s1_vld_a_reg    <= store_valid_reg[cur_col];
            s1_vld_b_reg    <= store_valid_reg[col_inc[COL_W-1:0]];
            fwd_word_reg    <= wr_word;
        end
        if (s1_valid_reg)
        begin
            left_reg <= self_bit;
        end
    end

endmodule

// File: src/goc_queue.sv
`timescale 1ns / 1ps

// Short result queue between the classifier and the output stage.
module goc_queue import goc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           push_item,
    input  logic              pop,
    output result_t           head,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    result_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/goc_back.sv
`timescale 1ns / 1ps

// Output register: drains the queue and drives the master side.
module goc_back import goc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  result_t               head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic    out_valid_reg;
    result_t out_item_reg;

    assign pop      = !empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_item_reg.row, out_item_reg.column, out_item_reg.pixel_class};
    assign m_tlast  = out_item_reg.last_of_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= head;
        end
    end

endmodule

// File: src/glyph_outline_classifier_core.sv
// Channel      Direction  Handshake               Payload
// pixel in     slave      s_tvalid / s_tready     s_tdata, s_tuser
// class out    master     m_tvalid / m_tready     m_tdata, m_tlast
// width write  config     cfg_we (no wait)        cfg_wdata
//
// One pixel request is taken every clock while the queue has room; its result
// passes the classify stage behind the registered line store read, then a
// queue slot, then the output register on the way to the master side.
// The line store is a two-bank RAM with one word per column and per-column
// written flags; reset clears the flags, counters and width at once, with no
// clearing pass. A queue of four results lets the output stall on its own;
// the input stalls once that queue and the classify stage hold four results.
`timescale 1ns / 1ps

module glyph_outline_classifier_core import goc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [WIDTH_W-1:0]     cfg_wdata,   // active_width
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CODE_W-1:0]      s_tdata,     // char_code
    input  logic [IN_USER_W-1:0]   s_tuser,     // first_of_frame, flush_row
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,     // pixel_class, column, row
    output logic                   m_tlast      // last_of_frame
);

    // Results handed from the classifier to the queue.
    logic              push;
    result_t           push_item;

    // Queue state seen by the front (space) and the back (head).
    result_t           head;
    logic              empty;
    logic              pop;
    logic [QCNT_W-1:0] q_count;

    // The front counts rows and columns, looks up the two stored rows and
    // classifies the pixel one row above the incoming request.
    goc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    // Requests in the top row produce no result, so the queue sees gaps.
    goc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (q_count)
    );

    // The back holds one result on the master side until it is taken.
    goc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: src/goc_checker.sv
`timescale 1ns / 1ps
`include "glyph_outline_classifier_core_macros.svh"

// Port-level checks for the outline classifier.
module goc_checker import goc_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // Only the three defined classes ever leave the block.
    `GOC_ASSERT_SAME(a_class_legal, m_tvalid, m_tdata[1:0] == CLASS_BACKGROUND || m_tdata[1:0] == CLASS_GLYPH || m_tdata[1:0] == CLASS_OUTLINE, "illegal pixel class")

    // With the output register empty the queue cannot be full.
    `GOC_ASSERT_SAME(a_ready_when_drained, !m_tvalid, s_tready, "input stalled while output empty")

    // A stalled result holds its payload.
    `GOC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind glyph_outline_classifier_core goc_checker u_checker (.*);
